### hw/rtl/varkey_pkg.sv
// Package: shared widths and defaults for the varint key encoder.
`timescale 1ns / 1ps

package varkey_pkg;

    localparam int KEY_FIELD_W   = 64;          // width of the key word on the port
    localparam int KEY_W_DEFAULT = 64;          // default count of key bits that are encoded
    localparam int DIGIT_W       = 7;           // bits of key per code byte
    localparam int BYTE_W        = 8;           // width of one code byte

    typedef logic [KEY_FIELD_W-1:0]  key_t;
    typedef logic signed [BYTE_W-1:0] code_byte_t;

endpackage

### hw/rtl/varkey_if.sv
// Interfaces: valid/ready channels for key words and code byte words.
`timescale 1ns / 1ps

interface varkey_key_if;
    import varkey_pkg::*;

    logic valid;
    logic ready;
    key_t key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface varkey_code_if;
    import varkey_pkg::*;

    logic       valid;
    logic       ready;
    code_byte_t code_byte;
    logic       last;

    modport source (output valid, output code_byte, output last, input ready);
    modport sink   (input valid, input code_byte, input last, output ready);
endinterface

### hw/rtl/varint_key_encoder.sv
// Top level: varint key encoder, one 7-bit digit per cycle from a shift register while the output is not stalled.
`timescale 1ns / 1ps
// Flow: a taken key passes from idle to a scan state and then to an emit state; the next
//   key is taken only after its final byte is loaded (GROUPS = ceil(KEY_WIDTH/7) digits).
// The digit shift register walks every 7-bit digit once: leading zero digits are dropped
//   (at least one is kept), the rest leave one per cycle while the output is not stalled.
// The output register holds a finished byte while the next key is taken.
// Reset (rst_n, asynchronous, active low) returns to idle with no byte pending.

module varint_key_encoder
#(
    parameter int KEY_WIDTH = varkey_pkg::KEY_W_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    varkey_key_if.sink     key_ch,
    varkey_code_if.source  code_ch
);

    import varkey_pkg::*;

    // Digit count and padded shift register width.
    localparam int GROUPS = (KEY_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int SR_W   = GROUPS * DIGIT_W;
    localparam int CNT_W  = $clog2(GROUPS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [SR_W-1:0]      sr_reg, sr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;      // digits still in the shift register
    logic                 out_valid_reg, out_valid_next;
    code_byte_t           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;

    logic [DIGIT_W-1:0]   top_digit;
    logic                 one_left;
    logic                 out_free;

    // The most significant digit always sits at the top of the shift register.
    assign top_digit = sr_reg[SR_W-1 -: DIGIT_W];
    assign one_left  = (cnt_reg == CNT_W'(1));
    assign out_free  = !out_valid_reg || code_ch.ready;

    // Take a key only when no digit of the previous one is left.
    assign key_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        sr_next        = sr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !code_ch.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (key_ch.valid)
                begin
                    // Load the masked key, zero padded up to a whole digit.
                    sr_next    = SR_W'(key_ch.key[KEY_WIDTH-1:0]);
                    cnt_next   = CNT_W'(GROUPS);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Drop leading zero digits; keep at least one.
                if ((top_digit == '0) && !one_left)
                begin
                    sr_next  = sr_reg << DIGIT_W;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    // Byte is (digit<<1 | more) with its top bit inverted.
                    out_valid_next = 1'b1;
                    out_byte_next  = {~top_digit[DIGIT_W-1], top_digit[DIGIT_W-2:0],
                                      !one_left};
                    out_last_next  = one_left;
                    sr_next        = sr_reg << DIGIT_W;
                    cnt_next       = cnt_reg - CNT_W'(1);
                    if (one_left)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        sr_reg       <= sr_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign code_ch.valid     = out_valid_reg;
    assign code_ch.code_byte = out_byte_reg;
    assign code_ch.last      = out_last_reg;

endmodule

### hw/rtl/varkey_checker.sv
// Checker: port-level properties of the varint key encoder, bound to the top level.
`timescale 1ns / 1ps

module varkey_checker
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   key_valid,
    input logic                   key_ready,
    input logic                   code_valid,
    input logic                   code_ready,
    input varkey_pkg::code_byte_t code_byte,
    input logic                   code_last
);

    import varkey_pkg::*;

    // A stalled code word holds.
    a_code_hold: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_ready |=> code_valid && $stable(code_byte) && $stable(code_last))
        else $error("code word changed while stalled");

    // The continuation bit is set exactly on bytes that are not final.
    a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> (code_byte[0] == !code_last))
        else $error("continuation bit disagrees with last");

    // A taken key closes the input until its bytes are done.
    a_busy_after_key: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready |=> !key_ready)
        else $error("key accepted while previous key still in work");

    // While a non-final byte waits, the rest of its key is still pending.
    a_no_key_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_last |-> !key_ready)
        else $error("input open in the middle of a byte run");

endmodule

bind varint_key_encoder varkey_checker u_varkey_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_valid  (key_ch.valid),
    .key_ready  (key_ch.ready),
    .code_valid (code_ch.valid),
    .code_ready (code_ch.ready),
    .code_byte  (code_ch.code_byte),
    .code_last  (code_ch.last)
);
